[rtl/core/assert_macros.svh]
// Assertion macros used by the scan peak search top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset
`define GS_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent
`define GS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/gscan_pkg.sv]
// Types, constants and codes of the serpentine grid scan peak search
`timescale 1ns / 1ps
package gscan_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int POS_BITS_DEF   = 32;

	localparam int STEP_W  = 20;
	localparam int PTS_W   = 11;
	localparam int OFF_W   = 31;
	localparam int VAL_W   = 32;
	localparam int OUT_IDX_W = 10;
	localparam int CIDX_W  = 2;

	localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(1000000);

	localparam logic [STEP_W-1:0] X_STEP_RST = STEP_W'(50000);
	localparam logic [STEP_W-1:0] Y_STEP_RST = STEP_W'(10000);
	localparam logic [PTS_W-1:0]  X_PTS_RST  = PTS_W'(2);
	localparam logic [PTS_W-1:0]  Y_PTS_RST  = PTS_W'(5);
	localparam logic [OFF_W-1:0]  X_OFF_RST  = OFF_W'(50000);
	localparam logic [OFF_W-1:0]  Y_OFF_RST  = OFF_W'(40000);

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_X_STEP = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_Y_STEP = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_X_PTS  = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_Y_PTS  = 2'd3;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_SKIP   = 2'd2,
		OP_STOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_MOVE    = 2'd0,
		ST_DONE    = 2'd1,
		ST_STOPPED = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	// What the position stages produce for a transaction
	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_GRID = 2'd1,
		TGT_HOME = 2'd2
	} tgt_t;

	typedef struct packed {
		logic [STEP_W-1:0] x_step;
		logic [STEP_W-1:0] y_step;
		logic [PTS_W-1:0]  x_points;
		logic [PTS_W-1:0]  y_points;
		logic [OFF_W-1:0]  x_off;
		logic [OFF_W-1:0]  y_off;
	} cfg_t;

	typedef struct packed {
		status_t                   status;
		tgt_t                      kind;
		logic [PTS_W-1:0]          row;
		logic [PTS_W-1:0]          col;
		logic signed [VAL_W-1:0]   home_x;
		logic signed [VAL_W-1:0]   home_y;
		logic signed [VAL_W-1:0]   recorded;
		logic signed [VAL_W-1:0]   best_value;
		logic [PTS_W-1:0]          best_row;
		logic [PTS_W-1:0]          best_col;
		logic                      best_found;
	} item_t;

endpackage

[rtl/core/gscan_cfg.sv]
// Configuration registers with clamping and precomputed grid half spans
`timescale 1ns / 1ps
module gscan_cfg #(
	parameter int MAX_POINTS = gscan_pkg::MAX_POINTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gscan_pkg::CIDX_W-1:0] cfg_index,
	input  logic [gscan_pkg::STEP_W-1:0] cfg_data,
	input  logic                         busy,
	output gscan_pkg::cfg_t              cfg
);
	import gscan_pkg::*;

	logic [STEP_W-1:0] x_step_q, y_step_q, step_w;
	logic [PTS_W-1:0]  x_pts_q, y_pts_q, pts_w;
	logic [OFF_W-1:0]  x_off_q, y_off_q, x_off_d, y_off_d;

	// Clamp incoming values
	always_comb begin
		step_w = (cfg_data > STEP_LIMIT) ? STEP_LIMIT : cfg_data;
		pts_w  = cfg_data[PTS_W-1:0];
		if (pts_w == '0) begin
			pts_w = PTS_W'(1);
		end else if (32'(pts_w) > MAX_POINTS) begin
			pts_w = PTS_W'(MAX_POINTS);
		end
	end

	// Register writes, dropped while a scan runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_step_q <= X_STEP_RST;
			y_step_q <= Y_STEP_RST;
			x_pts_q  <= X_PTS_RST;
			y_pts_q  <= Y_PTS_RST;
		end else if (cfg_we && !busy) begin
			unique case (cfg_index)
				CFG_X_STEP: x_step_q <= step_w;
				CFG_Y_STEP: y_step_q <= step_w;
				CFG_X_PTS:  x_pts_q  <= pts_w;
				CFG_Y_PTS:  y_pts_q  <= pts_w;
				default: ;
			endcase
		end
	end

	// Half span of the grid in half-nm: (points - 1) * step
	assign x_off_d = OFF_W'(x_pts_q - PTS_W'(1)) * OFF_W'(x_step_q);
	assign y_off_d = OFF_W'(y_pts_q - PTS_W'(1)) * OFF_W'(y_step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q <= X_OFF_RST;
			y_off_q <= Y_OFF_RST;
		end else begin
			x_off_q <= x_off_d;
			y_off_q <= y_off_d;
		end
	end

	assign cfg = '{x_step: x_step_q, y_step: y_step_q, x_points: x_pts_q,
		y_points: y_pts_q, x_off: x_off_q, y_off: y_off_q};

endmodule

[rtl/core/gscan_seq.sv]
// Scan sequencer: grid position, peak tracking and first pipeline stage
`timescale 1ns / 1ps
module gscan_seq #(
	parameter int MAX_POINTS = gscan_pkg::MAX_POINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [1:0]                        op,
	input  logic signed [gscan_pkg::VAL_W-1:0] origin_x,
	input  logic signed [gscan_pkg::VAL_W-1:0] origin_y,
	input  logic signed [gscan_pkg::VAL_W-1:0] reading,
	input  logic                              reading_ok,
	input  gscan_pkg::cfg_t                   cfg,
	output logic                              busy,
	output gscan_pkg::item_t                  item_s1
);
	import gscan_pkg::*;

	localparam int IDX_W = ($clog2(MAX_POINTS) < PTS_W) ? $clog2(MAX_POINTS) : PTS_W;

	logic                    busy_q, busy_d;
	logic [IDX_W-1:0]        row_q, row_d, step_q, step_d;
	logic signed [VAL_W-1:0] home_x_q, home_x_d, home_y_q, home_y_d;
	logic signed [VAL_W-1:0] peak_q, peak_d, last_q, last_d;
	logic [IDX_W-1:0]        peak_row_q, peak_row_d, peak_col_q, peak_col_d;
	logic                    seen_q, seen_d;
	logic signed [VAL_W-1:0] value;
	logic [PTS_W-1:0]        col_cur, col_nx;
	logic [PTS_W:0]          step_inc, row_inc;
	logic                    row_wrap, grid_end;
	item_t                   item_d;

	function automatic logic [PTS_W-1:0] col_of(input logic [PTS_W-1:0] row,
		input logic [PTS_W-1:0] step, input logic [PTS_W-1:0] pts);
		return row[0] ? (pts - PTS_W'(1) - step) : step;
	endfunction

	// Current column and the position after one advance
	always_comb begin
		col_cur  = col_of(PTS_W'(row_q), PTS_W'(step_q), cfg.x_points);
		step_inc = (PTS_W+1)'(step_q) + (PTS_W+1)'(1);
		row_inc  = (PTS_W+1)'(row_q) + (PTS_W+1)'(1);
		row_wrap = step_inc >= {1'b0, cfg.x_points};
		grid_end = row_wrap && (row_inc >= {1'b0, cfg.y_points});
		value    = reading_ok ? reading : last_q;
	end

	// Next state and stage one payload
	always_comb begin
		busy_d     = busy_q;
		row_d      = row_q;
		step_d     = step_q;
		home_x_d   = home_x_q;
		home_y_d   = home_y_q;
		peak_d     = peak_q;
		peak_row_d = peak_row_q;
		peak_col_d = peak_col_q;
		seen_d     = seen_q;
		last_d     = last_q;
		col_nx     = '0;
		item_d     = '0;
		item_d.status = ST_IGNORED;
		item_d.kind   = TGT_NONE;
		item_d.home_x = home_x_q;
		item_d.home_y = home_y_q;

		if (op_t'(op) == OP_START) begin
			if (!busy_q) begin
				busy_d     = 1'b1;
				row_d      = '0;
				step_d     = '0;
				home_x_d   = origin_x;
				home_y_d   = origin_y;
				peak_d     = '0;
				peak_row_d = '0;
				peak_col_d = '0;
				seen_d     = 1'b0;
				item_d.status = ST_MOVE;
				item_d.kind   = TGT_GRID;
				item_d.home_x = origin_x;
				item_d.home_y = origin_y;
			end
		end else if (busy_q) begin
			if (op_t'(op) == OP_STOP) begin
				busy_d = 1'b0;
				row_d  = '0;
				step_d = '0;
				item_d.status = ST_STOPPED;
			end else begin
				// Record the sample and update the peak
				if (op_t'(op) == OP_SAMPLE) begin
					last_d = value;
					if (!seen_q || (value > peak_q)) begin
						peak_d     = value;
						peak_row_d = row_q;
						peak_col_d = IDX_W'(col_cur);
						seen_d     = 1'b1;
					end
					item_d.recorded = value;
				end
				// Advance along the serpentine path
				if (grid_end) begin
					busy_d = 1'b0;
					row_d  = '0;
					step_d = '0;
					item_d.status = ST_DONE;
					item_d.kind   = TGT_HOME;
				end else begin
					if (row_wrap) begin
						step_d = '0;
						row_d  = IDX_W'(row_inc);
					end else begin
						step_d = IDX_W'(step_inc);
					end
					col_nx = col_of(PTS_W'(row_d), PTS_W'(step_d), cfg.x_points);
					item_d.status = ST_MOVE;
					item_d.kind   = TGT_GRID;
					item_d.row    = PTS_W'(row_d);
					item_d.col    = col_nx;
				end
			end
		end

		item_d.best_value = peak_d;
		item_d.best_row   = PTS_W'(peak_row_d);
		item_d.best_col   = PTS_W'(peak_col_d);
		item_d.best_found = seen_d;
	end

	// Scan control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			row_q      <= '0;
			step_q     <= '0;
			home_x_q   <= '0;
			home_y_q   <= '0;
			peak_q     <= '0;
			peak_row_q <= '0;
			peak_col_q <= '0;
			seen_q     <= 1'b0;
			last_q     <= '0;
		end else if (accept) begin
			busy_q     <= busy_d;
			row_q      <= row_d;
			step_q     <= step_d;
			home_x_q   <= home_x_d;
			home_y_q   <= home_y_d;
			peak_q     <= peak_d;
			peak_row_q <= peak_row_d;
			peak_col_q <= peak_col_d;
			seen_q     <= seen_d;
			last_q     <= last_d;
		end
	end

	// Stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

	assign busy = busy_q;

endmodule

[rtl/core/gscan_pos.sv]
// Target position: per-axis multiply stage, then offset add and saturation
`timescale 1ns / 1ps
module gscan_pos #(
	parameter int POS_BITS = gscan_pkg::POS_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en_s2,
	input  logic                              en_s3,
	input  gscan_pkg::cfg_t                   cfg,
	input  gscan_pkg::item_t                  item_s1,
	output gscan_pkg::item_t                  item_s3,
	output logic signed [gscan_pkg::VAL_W-1:0] target_x_s3,
	output logic signed [gscan_pkg::VAL_W-1:0] target_y_s3
);
	import gscan_pkg::*;

	localparam int SUM_W = (POS_BITS > 35) ? POS_BITS + 1 : 36;
	localparam logic signed [SUM_W-1:0] POS_HI =
		SUM_W'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] POS_LO = -POS_HI - SUM_W'(1);

	item_t                   item_s2;
	logic [OFF_W-1:0]        prod_x_s2, prod_y_s2;
	logic signed [SUM_W-1:0] hx, hy, ox, oy, px, py, sum_x, sum_y, sat_x, sat_y;

	// Column and row times step
	always_ff @(posedge clk) begin
		if (en_s2) begin
			item_s2   <= item_s1;
			prod_x_s2 <= OFF_W'(item_s1.col) * OFF_W'(cfg.x_step);
			prod_y_s2 <= OFF_W'(item_s1.row) * OFF_W'(cfg.y_step);
		end
	end

	// Grid position from the center; the return target is the center itself
	always_comb begin
		hx = SUM_W'(item_s2.home_x);
		hy = SUM_W'(item_s2.home_y);
		ox = '0;
		oy = '0;
		px = '0;
		py = '0;
		if (item_s2.kind == TGT_GRID) begin
			ox = SUM_W'(cfg.x_off);
			oy = SUM_W'(cfg.y_off);
			px = SUM_W'({prod_x_s2, 1'b0});
			py = SUM_W'({prod_y_s2, 1'b0});
		end
		sum_x = hx - ox + px;
		sum_y = hy + oy - py;
		sat_x = (sum_x > POS_HI) ? POS_HI : ((sum_x < POS_LO) ? POS_LO : sum_x);
		sat_y = (sum_y > POS_HI) ? POS_HI : ((sum_y < POS_LO) ? POS_LO : sum_y);
	end

	// Result register
	always_ff @(posedge clk) begin
		if (en_s3) begin
			item_s3 <= item_s2;
			if (item_s2.kind == TGT_NONE) begin
				target_x_s3 <= '0;
				target_y_s3 <= '0;
			end else begin
				target_x_s3 <= VAL_W'(sat_x);
				target_y_s3 <= VAL_W'(sat_y);
			end
		end
	end

endmodule

[rtl/core/serpentine_grid_scan_peak_search_top.sv]
// Throughput: one transaction per cycle unless stalled; sequencer state updates at accept.
// Three registered stages (sequencer, multiply, add and saturate) stall only
// when the result register is full and not taken; empty stages still fill.
// Reset: arst_n clears scan state, peak state and valids, and loads the
// configuration defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module serpentine_grid_scan_peak_search_top #(
	parameter int MAX_POINTS = gscan_pkg::MAX_POINTS_DEF,
	parameter int POS_BITS   = gscan_pkg::POS_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [gscan_pkg::CIDX_W-1:0]          cfg_index,
	input  logic [gscan_pkg::STEP_W-1:0]          cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            op,
	input  logic signed [gscan_pkg::VAL_W-1:0]    origin_x,
	input  logic signed [gscan_pkg::VAL_W-1:0]    origin_y,
	input  logic signed [gscan_pkg::VAL_W-1:0]    reading,
	input  logic                                  reading_ok,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [gscan_pkg::VAL_W-1:0]    target_x,
	output logic signed [gscan_pkg::VAL_W-1:0]    target_y,
	output logic [gscan_pkg::OUT_IDX_W-1:0]       target_row,
	output logic [gscan_pkg::OUT_IDX_W-1:0]       target_col,
	output logic signed [gscan_pkg::VAL_W-1:0]    recorded_value,
	output logic signed [gscan_pkg::VAL_W-1:0]    best_value,
	output logic [gscan_pkg::OUT_IDX_W-1:0]       best_row,
	output logic [gscan_pkg::OUT_IDX_W-1:0]       best_col,
	output logic                                  best_found,
	output logic [1:0]                            status
);
	import gscan_pkg::*;

	cfg_t  cfg;
	item_t item_s1, item_s3;
	logic  busy, accept;
	logic  valid_s1, valid_s2, valid_s3;
	logic  en_s1, en_s2, en_s3;

	// Stage enables: a stage loads when it is empty or its content moves on
	assign en_s3    = !valid_s3 || out_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	gscan_cfg #(.MAX_POINTS(MAX_POINTS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.cfg       (cfg)
	);

	gscan_seq #(.MAX_POINTS(MAX_POINTS)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (op),
		.origin_x   (origin_x),
		.origin_y   (origin_y),
		.reading    (reading),
		.reading_ok (reading_ok),
		.cfg        (cfg),
		.busy       (busy),
		.item_s1    (item_s1)
	);

	gscan_pos #(.POS_BITS(POS_BITS)) u_pos (
		.clk         (clk),
		.en_s2       (en_s2),
		.en_s3       (en_s3),
		.cfg         (cfg),
		.item_s1     (item_s1),
		.item_s3     (item_s3),
		.target_x_s3 (target_x),
		.target_y_s3 (target_y)
	);

	// Drive the result ports from the result register
	assign out_valid      = valid_s3;
	assign target_row     = OUT_IDX_W'(item_s3.row);
	assign target_col     = OUT_IDX_W'(item_s3.col);
	assign recorded_value = item_s3.recorded;
	assign best_value     = item_s3.best_value;
	assign best_row       = OUT_IDX_W'(item_s3.best_row);
	assign best_col       = OUT_IDX_W'(item_s3.best_col);
	assign best_found     = item_s3.best_found;
	assign status         = item_s3.status;

	`GS_ASSERT_IMPL(a_stall_needs_result, clk, arst_n, !in_ready, out_valid, "input stalled without a held result")
	`GS_ASSERT_IMPL(a_no_move_zero, clk, arst_n, out_valid && (status == ST_IGNORED || status == ST_STOPPED), target_x == '0 && target_y == '0 && recorded_value == '0, "ignored or stopped transaction carries a target")
	`GS_ASSERT_IMPL(a_return_origin_idx, clk, arst_n, out_valid && status == ST_DONE, target_row == '0 && target_col == '0, "return target has nonzero grid index")
	`GS_ASSERT_IMPL(a_no_peak_clear, clk, arst_n, out_valid && !best_found, best_value == '0 && best_row == '0 && best_col == '0, "peak fields set with no recorded value")

endmodule
